/* rtl/core/bgd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgd_pkg: shared types and constants of the button gesture detector
// Widths, register indexes, reset values, gesture and event codes, and the
// queue item and configuration structs used by front, engine and top level.
// ---------------------------------------------------------------------------
package bgd_pkg;

    // Number of buttons watched (1 to 8)
    localparam int NUM_BUTTONS = 5;

    // Field widths fixed by the stream format
    localparam int BTN_W   = 3;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int IDLE_W  = 5;
    localparam int RCNT_W  = 3;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Button select width for the state arrays
    localparam int BSEL_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Idle levels widened so that every button index has a bit
    localparam int IDLE_EXT_W = 1 << BTN_W;

    // Stream data widths (fields packed from bit 0, padded to bytes)
    localparam int S_DATA_W = ((BTN_W + 1 + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((BTN_W + CODE_W + 7) / 8) * 8;

    localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THROTTLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IDLE     = 3'd5;

    // Configuration reset values
    localparam logic [CFG_W-1:0]  PRESS_TIME_RST   = 16'd10;
    localparam logic [CFG_W-1:0]  HOLD_TIME_RST    = 16'd350;
    localparam logic [CFG_W-1:0]  RELEASE_TIME_RST = 16'd10;
    localparam logic [CFG_W-1:0]  CLICK_GAP_RST    = 16'd120;
    localparam logic [CFG_W-1:0]  THROTTLE_RST     = 16'd2;
    localparam logic [IDLE_W-1:0] IDLE_LEVELS_RST  = 5'd31;

    // Per-button gesture state
    typedef enum logic [6:0] {
        G_IDLE     = 7'b0000001,
        G_FRONT    = 7'b0000010,
        G_PRESSED  = 7'b0000100,
        G_HELD     = 7'b0001000,
        G_BACK     = 7'b0010000,
        G_RELEASED = 7'b0100000,
        G_CLICKED  = 7'b1000000
    } gesture_t;

    // Reported event codes
    typedef enum logic [CODE_W-1:0] {
        EV_PRESSED  = 3'd0,
        EV_HELD     = 3'd1,
        EV_RELEASED = 3'd2,
        EV_CLICK    = 3'd3,
        EV_DOUBLE   = 3'd4,
        EV_TRIPLE   = 3'd5,
        EV_MULTIPLE = 3'd6
    } event_code_t;

    // Classified item waiting between front and engine
    typedef struct packed {
        logic              is_tick;
        logic [BTN_W-1:0]  idx;
        logic              level;
        logic [TIME_W-1:0] now;
    } item_t;

    // Configuration register set
    typedef struct packed {
        logic [CFG_W-1:0]  press_time;
        logic [CFG_W-1:0]  hold_time;
        logic [CFG_W-1:0]  release_time;
        logic [CFG_W-1:0]  click_gap;
        logic [CFG_W-1:0]  throttle;
        logic [IDLE_W-1:0] idle_levels;
    } cfg_t;

    // Idle level of one button; buttons beyond the register width idle low
    function automatic logic idle_bit(input logic [IDLE_W-1:0] levels,
                                      input logic [BTN_W-1:0] b);
        logic [IDLE_EXT_W-1:0] ext;
        ext = IDLE_EXT_W'(levels);
        return ext[b];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/button_gesture_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// button_gesture_detector: push button gesture detector, top level
// Holds the configuration registers and joins the input front end to the
// gesture engine.
// ---------------------------------------------------------------------------
// Usage:
// - Input stream (s_): one transaction per pin change (s_tuser = 0, with
//   button index, pin level and time) or per timer tick (s_tuser = 1, time).
// - Output stream (m_): one transaction per gesture event; m_tlast marks the
//   final event caused by a tick. Pin changes cause no events.
// - The engine applies a pin change as it takes it from the queue. A tick
//   walks the buttons one a cycle, and the walk holds while the receiver
//   stalls.
// - A two-entry queue sits between front end and engine, so transactions are
//   taken while a tick is still being walked; s_tready drops only when it is
//   full. An event waits in a pending register until the walk finds the
//   next event of the tick or ends; after the walk visits the final button,
//   a drain step moves the last event into the output register.
// - When m_tready is low the output register holds; the walk holds on the
//   next event, and the queue fills before s_tready drops.
// - Reset (aresetn low, synchronous) sets every button to idle with its
//   level at the idle level, clears queue and outputs, and loads default
//   timings. Write configuration (cfg_we, cfg_index, cfg_wdata) only while
//   the block is idle.
// ---------------------------------------------------------------------------
module button_gesture_detector (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [bgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bgd_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: button_index [2:0], pin_level [3], now_ms [35:4], zero pad
    input  wire logic [bgd_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: func [0] (0 pin change, 1 tick)
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: event_button [2:0], event_code [5:3], zero pad
    output logic [bgd_pkg::M_DATA_W-1:0]           m_tdata,
    output logic                                   m_tlast
);
    import bgd_pkg::*;

    cfg_t  cfg_reg;
    logic  head_valid;
    item_t head;
    logic  pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_time   <= PRESS_TIME_RST;
            cfg_reg.hold_time    <= HOLD_TIME_RST;
            cfg_reg.release_time <= RELEASE_TIME_RST;
            cfg_reg.click_gap    <= CLICK_GAP_RST;
            cfg_reg.throttle     <= THROTTLE_RST;
            cfg_reg.idle_levels  <= IDLE_LEVELS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_PRESS:    cfg_reg.press_time   <= cfg_wdata;
                CFG_IDX_HOLD:     cfg_reg.hold_time    <= cfg_wdata;
                CFG_IDX_RELEASE:  cfg_reg.release_time <= cfg_wdata;
                CFG_IDX_GAP:      cfg_reg.click_gap    <= cfg_wdata;
                CFG_IDX_THROTTLE: cfg_reg.throttle     <= cfg_wdata;
                CFG_IDX_IDLE:     cfg_reg.idle_levels  <= cfg_wdata[IDLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bgd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    bgd_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

/* rtl/core/bgd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgd_front: input classification and item queue
// Accepts stream transactions, drops pin changes for buttons that do not
// exist, and queues the rest in order for the gesture engine.
// ---------------------------------------------------------------------------
module bgd_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // s_tdata: button_index [2:0], pin_level [3], now_ms [35:4], zero pad
    input  wire logic [bgd_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: func [0] (0 pin change, 1 tick)
    input  wire logic [0:0]                   s_tuser,
    output logic                              head_valid,
    output bgd_pkg::item_t                    head,
    input  wire logic                         pop
);
    import bgd_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [BTN_W:0] NUM_BTN_X = (BTN_W + 1)'(NUM_BUTTONS);

    item_t            q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    item_t in_item;
    logic  in_keep;
    logic  push;
    logic  do_pop;

    // Unpack and classify the incoming transaction
    always_comb begin
        in_item.is_tick = s_tuser[0];
        in_item.idx     = s_tdata[BTN_W-1:0];
        in_item.level   = s_tdata[BTN_W];
        in_item.now     = s_tdata[BTN_W+1 +: TIME_W];
        in_keep = in_item.is_tick || ({1'b0, in_item.idx} < NUM_BTN_X);
    end

    assign s_tready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready && in_keep;
    assign do_pop     = pop && head_valid;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued items
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Fill level stays within the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

    // A dropped pin change never changes the fill level
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !in_keep && !do_pop) |=> $stable(count_reg))
        else $error("dropped item entered the queue");

    // A full queue that is not drained stays full and refuses transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && !do_pop) |=> !s_tready)
        else $error("full queue opened without a pop");

endmodule
`default_nettype wire

/* rtl/core/bgd_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgd_engine: gesture state per button and event generation
// Applies pin changes as it takes them and walks all buttons on a tick,
// one a cycle unless the output holds it. Events pass a pending register
// so that a tick's last event can be marked, then the output register.
// ---------------------------------------------------------------------------
module bgd_engine (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bgd_pkg::cfg_t                cfg,
    input  wire logic                         head_valid,
    input  wire bgd_pkg::item_t               head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // m_tdata: event_button [2:0], event_code [5:3], zero pad
    output logic [bgd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast
);
    import bgd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_DRAIN = 3'b100
    } eng_state_t;

    localparam logic [BSEL_W-1:0] LAST_BTN = BSEL_W'(NUM_BUTTONS - 1);

    eng_state_t         fsm_reg, fsm_next;
    logic [BSEL_W-1:0]  cursor_reg, cursor_next;
    logic [TIME_W-1:0]  tick_now_reg;
    logic               tick_now_we;

    // Per-button state
    gesture_t           gs_reg    [NUM_BUTTONS];
    gesture_t           prev_reg  [NUM_BUTTONS];
    logic               lvl_reg   [NUM_BUTTONS];
    logic [TIME_W-1:0]  stime_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]  ctime_reg [NUM_BUTTONS];
    logic [RCNT_W-1:0]  rcnt_reg  [NUM_BUTTONS];

    // Pending and output event registers
    logic               pend_valid_reg, pend_valid_next;
    logic [BTN_W-1:0]   pend_btn_reg, pend_btn_next;
    event_code_t        pend_code_reg, pend_code_next;
    logic               out_valid_reg, out_valid_next;
    logic [BTN_W-1:0]   out_btn_reg, out_btn_next;
    event_code_t        out_code_reg, out_code_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    // Selected entry and its write port
    logic [BSEL_W-1:0]  sel;
    gesture_t           cur_gs, cur_prev;
    logic               cur_lvl;
    logic [RCNT_W-1:0]  cur_rcnt;
    logic [TIME_W-1:0]  dt_state, dt_chg;
    logic               gs_we, lvl_we, st_we, ct_we, rc_we;
    gesture_t           gs_next;
    logic               lvl_next;
    logic [TIME_W-1:0]  st_next;
    logic [RCNT_W-1:0]  rc_next;

    // Tick evaluation of the selected button
    logic               w_gs_we, w_st_we, w_rc_we, w_ev;
    gesture_t           w_gs;
    logic [RCNT_W-1:0]  w_rc;
    event_code_t        w_code, click_code;
    logic               step_ok, out_free, pin_take;

    assign sel      = (fsm_reg == S_WALK) ? cursor_reg : head.idx[BSEL_W-1:0];
    assign cur_gs   = gs_reg[sel];
    assign cur_prev = prev_reg[sel];
    assign cur_lvl  = lvl_reg[sel];
    assign cur_rcnt = rcnt_reg[sel];
    assign dt_state = tick_now_reg - stime_reg[sel];
    assign dt_chg   = head.now - ctime_reg[sel];
    assign out_free = !out_valid_reg || m_tready;

    // Map the release count to a click code
    always_comb begin
        unique case (cur_rcnt)
            3'd1:    click_code = EV_CLICK;
            3'd2:    click_code = EV_DOUBLE;
            3'd3:    click_code = EV_TRIPLE;
            default: click_code = EV_MULTIPLE;
        endcase
    end

    // Advance the selected button on a tick
    always_comb begin
        w_gs_we = 1'b0;
        w_st_we = 1'b0;
        w_rc_we = 1'b0;
        w_ev    = 1'b0;
        w_gs    = cur_gs;
        w_rc    = cur_rcnt;
        w_code  = EV_PRESSED;
        unique case (cur_gs)
            G_FRONT: begin
                if (dt_state >= TIME_W'(cfg.press_time)) begin
                    w_gs_we = 1'b1;
                    w_gs    = G_PRESSED;
                    w_st_we = 1'b1;
                    w_ev    = 1'b1;
                    w_code  = EV_PRESSED;
                end
            end
            G_PRESSED: begin
                if (dt_state >= TIME_W'(cfg.hold_time)) begin
                    w_gs_we = 1'b1;
                    w_gs    = G_HELD;
                    w_st_we = 1'b1;
                    w_ev    = 1'b1;
                    w_code  = EV_HELD;
                end
            end
            G_HELD: begin
                w_rc_we = 1'b1;
                w_rc    = '0;
            end
            G_BACK: begin
                priority if (cur_prev == G_FRONT) begin
                    // Release right after a press edge is bounce noise
                    w_gs_we = 1'b1;
                    w_gs    = G_IDLE;
                end else if (dt_state >= TIME_W'(cfg.release_time)) begin
                    w_gs_we = 1'b1;
                    w_gs    = G_RELEASED;
                    w_st_we = 1'b1;
                    w_rc_we = 1'b1;
                    w_rc    = (cur_rcnt < RCNT_MAX) ? cur_rcnt + 1'b1 : cur_rcnt;
                    w_ev    = 1'b1;
                    w_code  = EV_RELEASED;
                end else begin
                    w_gs_we = 1'b0;
                end
            end
            G_RELEASED: begin
                if (dt_state >= TIME_W'(cfg.click_gap)) begin
                    w_gs_we = 1'b1;
                    w_gs    = G_CLICKED;
                    w_st_we = 1'b1;
                    w_rc_we = 1'b1;
                    w_rc    = '0;
                    w_ev    = 1'b1;
                    w_code  = click_code;
                end
            end
            G_CLICKED: begin
                w_gs_we = 1'b1;
                w_gs    = G_IDLE;
            end
            default: begin
                w_gs_we = 1'b0;
            end
        endcase
    end

    // Throttle and level check for a pin change
    assign pin_take = (dt_chg > TIME_W'(cfg.throttle)) && (head.level != cur_lvl);

    // Hold the walk while a second event finds the output full
    assign step_ok = !(w_ev && pend_valid_reg && !out_free);

    // Sequencer
    always_comb begin
        fsm_next        = fsm_reg;
        cursor_next     = cursor_reg;
        pop             = 1'b0;
        tick_now_we     = 1'b0;
        gs_we           = 1'b0;
        lvl_we          = 1'b0;
        st_we           = 1'b0;
        ct_we           = 1'b0;
        rc_we           = 1'b0;
        gs_next         = w_gs;
        lvl_next        = head.level;
        st_next         = tick_now_reg;
        rc_next         = w_rc;
        pend_valid_next = pend_valid_reg;
        pend_btn_next   = pend_btn_reg;
        pend_code_next  = pend_code_reg;
        out_load        = 1'b0;
        out_last_next   = 1'b0;
        unique case (fsm_reg)
            S_IDLE: begin
                if (head_valid) begin
                    pop = 1'b1;
                    if (head.is_tick) begin
                        tick_now_we = 1'b1;
                        cursor_next = '0;
                        fsm_next    = S_WALK;
                    end else if (pin_take) begin
                        gs_we   = 1'b1;
                        gs_next = (idle_bit(cfg.idle_levels, head.idx) != head.level)
                                  ? G_FRONT : G_BACK;
                        lvl_we  = 1'b1;
                        st_we   = 1'b1;
                        st_next = head.now;
                        ct_we   = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (step_ok) begin
                    gs_we = w_gs_we;
                    st_we = w_st_we;
                    rc_we = w_rc_we;
                    if (w_ev) begin
                        // Earlier event of this tick is not the last one
                        out_load        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_btn_next   = BTN_W'(cursor_reg);
                        pend_code_next  = w_code;
                    end
                    if (cursor_reg == LAST_BTN) begin
                        fsm_next = S_DRAIN;
                    end else begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                priority if (!pend_valid_reg) begin
                    fsm_next = S_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    fsm_next        = S_IDLE;
                end else begin
                    fsm_next = S_DRAIN;
                end
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // Output register: load from pending, clear once taken
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_btn_next   = out_btn_reg;
        out_code_next  = out_code_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_btn_next   = pend_btn_reg;
            out_code_next  = pend_code_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= S_IDLE;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            fsm_reg        <= fsm_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Event payload registers
    always_ff @(posedge aclk) begin
        pend_btn_reg  <= pend_btn_next;
        pend_code_reg <= pend_code_next;
        out_btn_reg   <= out_btn_next;
        out_code_reg  <= out_code_next;
        if (out_load) begin
            out_last_reg <= out_last_next;
        end
        if (tick_now_we) begin
            tick_now_reg <= head.now;
        end
    end

    // Button state: reset to idle, write the selected entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                gs_reg[b]    <= G_IDLE;
                prev_reg[b]  <= G_IDLE;
                lvl_reg[b]   <= idle_bit(IDLE_LEVELS_RST, BTN_W'(b));
                stime_reg[b] <= '0;
                ctime_reg[b] <= '0;
                rcnt_reg[b]  <= '0;
            end
        end else begin
            if (gs_we) begin
                prev_reg[sel] <= cur_gs;
                gs_reg[sel]   <= gs_next;
            end
            if (lvl_we) begin
                lvl_reg[sel] <= lvl_next;
            end
            if (st_we) begin
                stime_reg[sel] <= st_next;
            end
            if (ct_we) begin
                ctime_reg[sel] <= head.now;
            end
            if (rc_we) begin
                rcnt_reg[sel] <= rc_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_code_reg, out_btn_reg});
    assign m_tlast  = out_last_reg;

    // No event may wait once the engine is back to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending event left behind after a tick");

    // The final event of a tick is only sent from the drain step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last_next) |-> (fsm_reg == S_DRAIN))
        else $error("last event marked outside drain");

    // The walk cursor stays on an existing button
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == S_WALK) |-> (cursor_reg <= LAST_BTN))
        else $error("walk cursor out of range");

    // A tick taken from the queue starts a walk at the first button
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == S_IDLE && head_valid && head.is_tick)
        |=> (fsm_reg == S_WALK && cursor_reg == '0))
        else $error("tick did not start a walk");

    // The output is never overwritten while it waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten");

endmodule
`default_nettype wire
